/* rtl/core/scmv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmv_pkg: shared types and constants for the sparse matrix-vector unit
// Field widths, item kinds, register indexes and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package scmv_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int IDX_W     = 10;
    localparam int EXT_W     = 17;
    localparam int COEF_W    = 32;
    localparam int YVAL_W    = 48;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int FRAC_W    = 16;
    localparam int CCNT_W    = 11;
    localparam int CFG_IW    = 1;
    localparam int CFG_DW    = 11;

    typedef enum logic [1:0] {
        KIND_LOAD_X  = 2'd0,
        KIND_LOAD_Y  = 2'd1,
        KIND_NONZERO = 2'd2,
        KIND_READ_Y  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TRANSPOSE = 1'd0,
        CFG_COL_COUNT = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic accept;
        logic mac_mul;
        logic mac_add;
        logic out_load;
    } scmv_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  mac_ok;
        logic  out_full;
    } scmv_status_t;

    function automatic logic [VEC_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] w;
        w = EXT_W'(idx);
        return w[VEC_AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return EXT_W'(idx) < EXT_W'(VEC_DEPTH);
    endfunction

endpackage

/* rtl/core/sparse_csc_matvec_accumulate_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_csc_matvec_accumulate_unit: sparse matrix-vector accumulator
// Loads x and y, accumulates y += A*x or y += A'*x from a stream of nonzero
// items with Q16.16 saturating fixed-point arithmetic, and reads y back.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  s_        in         s_valid / s_ready       kind, col, row, coeff, y_value
//  m_        out        m_valid / m_ready       out_index, out_value, overflow
//  cfg_      in         cfg_we                  cfg_index, cfg_wdata
//
// One item is in work at a time. Loads and dropped nonzeros finish when taken;
// a nonzero steps through store read, multiply, and add and write back; a read
// reads the store, then waits while the output register still holds an
// untaken item. Reset is synchronous and active low and needs no clearing
// pass; store contents are undefined until written. A stall on m_ready holds
// the output register; a further read item is taken, then holds off all input.
module sparse_csc_matvec_accumulate_unit
    import scmv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IW-1:0]         cfg_index,
    input  logic [CFG_DW-1:0]         cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic [IDX_W-1:0]          s_col_index,
    input  logic [IDX_W-1:0]          s_row_index,
    input  logic signed [COEF_W-1:0]  s_coeff,
    input  logic signed [YVAL_W-1:0]  s_y_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_out_index,
    output logic signed [YVAL_W-1:0]  m_out_value,
    output logic                      m_overflow_seen
);

    scmv_cmd_t    cmd;
    scmv_status_t status;

    scmv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scmv_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_kind          (s_kind),
        .s_col_index     (s_col_index),
        .s_row_index     (s_row_index),
        .s_coeff         (s_coeff),
        .s_y_value       (s_y_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_index     (m_out_index),
        .m_out_value     (m_out_value),
        .m_overflow_seen (m_overflow_seen)
    );

endmodule

/* rtl/core/scmv_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmv_ctrl: sequencing controller
// Takes one item at a time and steps the datapath through the multiply,
// accumulate and read-out phases.
// ----------------------------------------------------------------------------
module scmv_ctrl
    import scmv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  scmv_status_t status,
    output scmv_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_RDOUT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    if (status.kind == KIND_NONZERO && status.mac_ok) begin
                        state_next = ST_MUL;
                    end else if (status.kind == KIND_READ_Y) begin
                        state_next = ST_RDOUT;
                    end
                end
            end
            ST_MUL: begin
                cmd.mac_mul = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                cmd.mac_add = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RDOUT: begin
                if (!status.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/scmv_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmv_datapath: vector stores, multiplier and saturating accumulator
// Holds the x and y stores, the configuration registers, the product and
// sum logic and the output register.
// ----------------------------------------------------------------------------
module scmv_datapath
    import scmv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  scmv_cmd_t                 cmd,
    output scmv_status_t              status,
    input  logic                      cfg_we,
    input  logic [CFG_IW-1:0]         cfg_index,
    input  logic [CFG_DW-1:0]         cfg_wdata,
    input  logic [1:0]                s_kind,
    input  logic [IDX_W-1:0]          s_col_index,
    input  logic [IDX_W-1:0]          s_row_index,
    input  logic signed [COEF_W-1:0]  s_coeff,
    input  logic signed [YVAL_W-1:0]  s_y_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_out_index,
    output logic signed [YVAL_W-1:0]  m_out_value,
    output logic                      m_overflow_seen
);

    logic signed [COEF_W-1:0] x_mem [VEC_DEPTH];
    logic signed [YVAL_W-1:0] y_mem [VEC_DEPTH];

    logic                     transpose_reg;
    logic [CCNT_W-1:0]        col_count_reg;
    logic                     ovf_reg;
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic signed [YVAL_W-1:0] out_value_reg;
    logic                     out_ovf_reg;

    logic signed [COEF_W-1:0] coeff_reg;
    logic [VEC_AW-1:0]        y_addr_reg;
    logic [IDX_W-1:0]         row_reg;
    logic                     row_ok_reg;
    logic signed [COEF_W-1:0] x_rd_reg;
    logic signed [YVAL_W-1:0] y_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;

    kind_t                    kind;
    logic [IDX_W-1:0]         y_idx;
    logic [IDX_W-1:0]         x_idx;
    logic [IDX_W-1:0]         y_rd_idx;
    logic                     row_ok;
    logic                     y_we;
    logic [VEC_AW-1:0]        y_waddr;
    logic signed [YVAL_W-1:0] y_wdata;
    logic signed [YVAL_W-1:0] prod_sh;
    logic signed [YVAL_W:0]   sum;
    logic signed [YVAL_W-1:0] sum_sat;
    logic                     sum_ovf;

    assign kind     = kind_t'(s_kind);
    assign y_idx    = transpose_reg ? s_col_index : s_row_index;
    assign x_idx    = transpose_reg ? s_row_index : s_col_index;
    assign y_rd_idx = (kind == KIND_READ_Y) ? s_row_index : y_idx;
    assign row_ok   = in_range(s_row_index);

    assign status.kind     = kind;
    assign status.mac_ok   = (CCNT_W'(s_col_index) < col_count_reg)
                             && in_range(y_idx) && in_range(x_idx);
    assign status.out_full = m_valid_reg && !m_ready;

    // The product of two Q16.16 values fits 64 bits, so the shifted value
    // always fits the accumulator width.
    assign prod_sh = prod_reg[PROD_W-1:FRAC_W];
    assign sum     = (YVAL_W+1)'(y_rd_reg) + (YVAL_W+1)'(prod_sh);
    assign sum_ovf = sum[YVAL_W] != sum[YVAL_W-1];

    always_comb begin
        sum_sat = sum[YVAL_W-1:0];
        if (sum_ovf) begin
            sum_sat = sum[YVAL_W] ? {1'b1, {(YVAL_W-1){1'b0}}}
                                  : {1'b0, {(YVAL_W-1){1'b1}}};
        end
    end

    assign y_we    = cmd.mac_add
                     || (cmd.accept && kind == KIND_LOAD_Y && row_ok);
    assign y_waddr = cmd.mac_add ? y_addr_reg : to_addr(s_row_index);
    assign y_wdata = cmd.mac_add ? sum_sat : s_y_value;

    always_ff @(posedge aclk) begin
        if (cmd.accept && kind == KIND_LOAD_X && row_ok) begin
            x_mem[to_addr(s_row_index)] <= s_coeff;
        end
        if (cmd.accept) begin
            x_rd_reg <= x_mem[to_addr(x_idx)];
        end
    end

    always_ff @(posedge aclk) begin
        if (y_we) begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (cmd.accept) begin
            y_rd_reg <= y_mem[to_addr(y_rd_idx)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            coeff_reg  <= s_coeff;
            y_addr_reg <= to_addr(y_idx);
            row_reg    <= s_row_index;
            row_ok_reg <= row_ok;
        end
        if (cmd.mac_mul) begin
            prod_reg <= PROD_W'(x_rd_reg) * PROD_W'(coeff_reg);
        end
        if (cmd.out_load) begin
            out_index_reg <= row_reg;
            out_value_reg <= row_ok_reg ? y_rd_reg : '0;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_reg <= 1'b0;
            col_count_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TRANSPOSE: transpose_reg <= cfg_wdata[0];
                    CFG_COL_COUNT: col_count_reg <= cfg_wdata[CCNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.mac_add && sum_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_index     = out_index_reg;
    assign m_out_value     = out_value_reg;
    assign m_overflow_seen = out_ovf_reg;

endmodule

/* rtl/core/scmv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmv_checker: port-level checks for the sparse matrix-vector unit
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module scmv_checker
    import scmv_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_kind,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [IDX_W-1:0]          m_out_index,
    input logic signed [YVAL_W-1:0]  m_out_value,
    input logic                      m_overflow_seen
);

    logic [1:0] pend_reg;
    logic       ovf_seen_reg;
    logic       rd_acc;
    logic       out_acc;

    assign rd_acc  = s_valid && s_ready && kind_t'(s_kind) == KIND_READ_Y;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            ovf_seen_reg <= 1'b0;
        end else begin
            pend_reg <= pend_reg + 2'(rd_acc) - 2'(out_acc);
            if (out_acc && m_overflow_seen) begin
                ovf_seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_index)
                                && $stable(m_out_value)
                                && $stable(m_overflow_seen))
        else $error("result item changed while stalled");

    a_result_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result item without a read item");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many read items in flight");

    a_busy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_acc |=> !s_ready)
        else $error("input taken during a read");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && ovf_seen_reg |-> m_overflow_seen)
        else $error("overflow flag cleared");

endmodule

bind sparse_csc_matvec_accumulate_unit scmv_checker u_scmv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_kind          (s_kind),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_index     (m_out_index),
    .m_out_value     (m_out_value),
    .m_overflow_seen (m_overflow_seen)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sparse matrix-vector accumulator
// Loads x and y entries, streams nonzero items in both orientations and under
// several column limits, and checks every y read-back against a fixed-point
// scoreboard that mirrors the stores, the saturation and the sticky flag.
// ----------------------------------------------------------------------------
module tb_top;
    import scmv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic signed [YVAL_W-1:0] Y_TOP = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [YVAL_W-1:0] Y_BOTTOM = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [IDX_W-1:0]         index;
        logic signed [YVAL_W-1:0] value;
        logic                     overflow;
    } y_read_t;

    class matvec_scoreboard;
        logic signed [COEF_W-1:0] x_mem [VEC_DEPTH];
        logic signed [YVAL_W-1:0] y_mem [VEC_DEPTH];
        bit      overflow;
        bit      transpose;
        int      col_limit;
        y_read_t expected_reads [$];
        int      errors;
        int      reads_checked;
        int      applied;
        int      dropped;
        int      saturations;

        function void set_register(cfg_idx_t idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_TRANSPOSE) begin
                transpose = data[0];
            end else begin
                col_limit = int'(data);
            end
        endfunction

        function void flag(string msg);
            if (errors < 10) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endfunction

        function void accumulate(logic [IDX_W-1:0] yi, logic [IDX_W-1:0] xi,
                                 logic signed [COEF_W-1:0] c);
            longint prod;
            longint sum;
            prod = (longint'(c) * longint'(x_mem[xi])) >>> FRAC_W;
            sum = longint'(y_mem[yi]) + prod;
            if (sum > longint'(Y_TOP)) begin
                sum = longint'(Y_TOP);
                overflow = 1'b1;
                saturations++;
            end else if (sum < longint'(Y_BOTTOM)) begin
                sum = longint'(Y_BOTTOM);
                overflow = 1'b1;
                saturations++;
            end
            y_mem[yi] = 48'(sum);
            applied++;
        endfunction

        function void note_item(kind_t k, logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                                logic signed [COEF_W-1:0] c,
                                logic signed [YVAL_W-1:0] yv);
            case (k)
                KIND_LOAD_X: x_mem[row] = c;
                KIND_LOAD_Y: y_mem[row] = yv;
                KIND_NONZERO: begin
                    if (int'(col) >= col_limit) begin
                        dropped++;
                    end else if (transpose) begin
                        accumulate(col, row, c);
                    end else begin
                        accumulate(row, col, c);
                    end
                end
                default: expected_reads.push_back('{row, y_mem[row], overflow});
            endcase
        endfunction

        function void check_read(logic [IDX_W-1:0] idx, logic signed [YVAL_W-1:0] val,
                                 logic ovf);
            y_read_t want;
            if (expected_reads.size() == 0) begin
                flag($sformatf("unexpected read result: index %0d value %0d", idx, val));
                return;
            end
            want = expected_reads.pop_front();
            reads_checked++;
            if (idx !== want.index) begin
                flag($sformatf("out_index expected %0d, got %0d", want.index, idx));
            end
            if (val !== want.value) begin
                flag($sformatf("out_value at %0d expected %0d, got %0d",
                               want.index, want.value, val));
            end
            if (ovf !== want.overflow) begin
                flag($sformatf("overflow_seen at %0d expected %0b, got %0b",
                               want.index, want.overflow, ovf));
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IW-1:0]        cfg_index;
    logic [CFG_DW-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_kind;
    logic [IDX_W-1:0]         s_col_index;
    logic [IDX_W-1:0]         s_row_index;
    logic signed [COEF_W-1:0] s_coeff;
    logic signed [YVAL_W-1:0] s_y_value;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [IDX_W-1:0]         m_out_index;
    logic signed [YVAL_W-1:0] m_out_value;
    logic                     m_overflow_seen;

    matvec_scoreboard sb;
    bit               calm = 1'b0;
    int               cycle_count = 0;
    int               items_sent = 0;
    int               settings_used = 0;
    logic [IDX_W-1:0] x_addrs [$];
    logic [IDX_W-1:0] y_addrs [$];
    bit               x_known [VEC_DEPTH];
    bit               y_known [VEC_DEPTH];

    sparse_csc_matvec_accumulate_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_col_index     (s_col_index),
        .s_row_index     (s_row_index),
        .s_coeff         (s_coeff),
        .s_y_value       (s_y_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_index     (m_out_index),
        .m_out_value     (m_out_value),
        .m_overflow_seen (m_overflow_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_read(m_out_index, m_out_value, m_overflow_seen);
        end
    end

    function automatic logic signed [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [YVAL_W-1:0] rand_y();
        case ($urandom_range(0, 7))
            0: return Y_TOP;
            1: return Y_BOTTOM;
            2, 3: return 48'($signed($urandom));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic bit pick_known(input bit from_x, input int bound,
                                      output logic [IDX_W-1:0] a);
        int n;
        n = from_x ? x_addrs.size() : y_addrs.size();
        a = '0;
        if (n == 0) begin
            return 1'b0;
        end
        for (int t = 0; t < 16; t++) begin
            a = from_x ? x_addrs[$urandom_range(0, n - 1)] : y_addrs[$urandom_range(0, n - 1)];
            if (int'(a) < bound) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input kind_t k, input logic [IDX_W-1:0] col,
                             input logic [IDX_W-1:0] row,
                             input logic signed [COEF_W-1:0] c,
                             input logic signed [YVAL_W-1:0] yv);
        while (!calm && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= k;
        s_col_index <= col;
        s_row_index <= row;
        s_coeff     <= c;
        s_y_value   <= yv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(k, col, row, c, yv);
        items_sent++;
        if (k == KIND_LOAD_X && !x_known[row]) begin
            x_known[row] = 1'b1;
            x_addrs.push_back(row);
        end
        if (k == KIND_LOAD_Y && !y_known[row]) begin
            y_known[row] = 1'b1;
            y_addrs.push_back(row);
        end
        @(negedge aclk);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (sb.expected_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_config(input bit tr, input int cc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TRANSPOSE;
        cfg_wdata <= CFG_DW'(tr);
        @(negedge aclk);
        cfg_index <= CFG_COL_COUNT;
        cfg_wdata <= CFG_DW'(cc);
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_register(CFG_TRANSPOSE, CFG_DW'(tr));
        sb.set_register(CFG_COL_COUNT, CFG_DW'(cc));
        settings_used++;
    endtask

    task automatic directed_items();
        logic signed [YVAL_W-1:0] junk;
        junk = rand_y();
        settle_block();
        write_config(1'b0, VEC_DEPTH);
        send_item(KIND_LOAD_X, 10'd3, 10'd0, 32'sh7FFF_FFFF, junk);
        send_item(KIND_LOAD_X, 10'd9, 10'd1023, 32'sh8000_0000, junk);
        send_item(KIND_LOAD_X, 10'd0, 10'd5, 32'sh0001_0000, junk);
        send_item(KIND_LOAD_X, 10'd1023, 10'd7, 32'sd1, junk);
        send_item(KIND_LOAD_Y, 10'd0, 10'd0, 32'sd0, 48'sd0);
        send_item(KIND_LOAD_Y, 10'd0, 10'd1023, 32'sd0, Y_TOP - 48'sd5);
        send_item(KIND_LOAD_Y, 10'd0, 10'd5, 32'sd0, Y_BOTTOM + 48'sd3);
        send_item(KIND_NONZERO, 10'd5, 10'd0, 32'sh0001_8000, junk);
        // A product of minus one in the last bit rounds down to minus one.
        send_item(KIND_NONZERO, 10'd7, 10'd0, -32'sd1, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd0, 32'sd0, junk);
        send_item(KIND_NONZERO, 10'd0, 10'd1023, 32'sh7FFF_FFFF, junk);
        send_item(KIND_NONZERO, 10'd1023, 10'd5, 32'sh7FFF_FFFF, junk);
        send_item(KIND_NONZERO, 10'd1023, 10'd0, 32'sh8000_0000, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd0, 32'sd0, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd1023, 32'sd0, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd5, 32'sd0, junk);
        settle_block();
        write_config(1'b1, 8);
        send_item(KIND_NONZERO, 10'd5, 10'd7, 32'sh0002_0000, junk);
        send_item(KIND_NONZERO, 10'd1023, 10'd0, 32'sh7FFF_FFFF, junk);
        send_item(KIND_NONZERO, 10'd8, 10'd5, 32'sh7FFF_FFFF, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd5, 32'sd0, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd1023, 32'sd0, junk);
        send_item(KIND_READ_Y, 10'd0, 10'd0, 32'sd0, junk);
    endtask

    task automatic random_item(input bit tr, input int cc);
        kind_t                    k;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         xa;
        logic [IDX_W-1:0]         ya;
        logic signed [COEF_W-1:0] c;
        logic signed [YVAL_W-1:0] yv;
        int                       roll;
        int                       lim;
        bit                       x_ok;
        bit                       y_ok;
        col  = 10'($urandom);
        row  = 10'($urandom);
        c    = rand_coeff();
        yv   = rand_y();
        lim  = (cc > VEC_DEPTH) ? VEC_DEPTH : cc;
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
            k = KIND_LOAD_X;
        end else if (roll < 28) begin
            k = KIND_LOAD_Y;
        end else if (roll < 80) begin
            k = KIND_NONZERO;
            if (lim > 0) begin
                if (roll >= 72 && lim < VEC_DEPTH) begin
                    col = 10'($urandom_range(lim, VEC_DEPTH - 1));
                end else begin
                    x_ok = pick_known(1'b1, tr ? VEC_DEPTH : lim, xa);
                    y_ok = pick_known(1'b0, tr ? lim : VEC_DEPTH, ya);
                    if (!x_ok) begin
                        k = KIND_LOAD_X;
                        if (!tr) begin
                            row = 10'($urandom_range(0, lim - 1));
                        end
                    end else if (!y_ok) begin
                        k = KIND_LOAD_Y;
                        if (tr) begin
                            row = 10'($urandom_range(0, lim - 1));
                        end
                    end else if (tr) begin
                        col = ya;
                        row = xa;
                    end else begin
                        col = xa;
                        row = ya;
                    end
                end
            end
        end else if (y_addrs.size() == 0) begin
            k = KIND_LOAD_Y;
        end else begin
            k = KIND_READ_Y;
            row = y_addrs[$urandom_range(0, y_addrs.size() - 1)];
        end
        send_item(k, col, row, c, yv);
    endtask

    task automatic random_phase(input bit tr, input int cc, input int count,
                                input bit quiet);
        settle_block();
        write_config(tr, cc);
        calm = quiet;
        repeat (count) random_item(tr, cc);
        calm = 1'b0;
    endtask

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_TRANSPOSE;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_kind      = KIND_LOAD_X;
        s_col_index = '0;
        s_row_index = '0;
        s_coeff     = '0;
        s_y_value   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_items();
        random_phase(1'b0, VEC_DEPTH, 120, 1'b0);
        random_phase(1'b1, VEC_DEPTH, 120, 1'b1);
        random_phase(1'b0, 0, 30, 1'b0);
        random_phase(1'b0, $urandom_range(1, VEC_DEPTH - 1), 110, 1'b0);
        random_phase(1'b1, $urandom_range(1, VEC_DEPTH - 1), 110, 1'b0);
        random_phase(1'b1, 1, 40, 1'b0);
        random_phase(1'b0, VEC_DEPTH - 1, 70, 1'b0);
        settle_block();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.expected_reads.size() != 0) begin
            sb.flag($sformatf("%0d reads never returned", sb.expected_reads.size()));
        end
        $display("Run covered %0d items under %0d register settings, both orientations",
                 items_sent, settings_used);
        $display("and column limits from 0 to 1024: %0d reads checked, %0d adds, %0d dropped, %0d saturated, %0d mismatches.",
                 sb.reads_checked, sb.applied, sb.dropped, sb.saturations, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
